// ----- hdl/button_gesture_pwm_duty_tracker_core_defines.svh -----
// ----------------------------------------------------------------------------
// Button gesture / PWM duty tracker - assertion macros
// Shared property wrappers for the core's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_PWM_DUTY_TRACKER_CORE_DEFINES_SVH
`define BUTTON_GESTURE_PWM_DUTY_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BGPDT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BGPDT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/bgpdt_pkg.sv -----
// ----------------------------------------------------------------------------
// bgpdt_pkg
// Types, constants and helpers shared by the gesture / duty tracker core.
// ----------------------------------------------------------------------------
package bgpdt_pkg;

	// register indexes on the write port
	localparam logic [2:0] REG_DEBOUNCE = 3'd0;
	localparam logic [2:0] REG_WINDOW   = 3'd1;
	localparam logic [2:0] REG_HOLD     = 3'd2;
	localparam logic [2:0] REG_BLINK    = 3'd3;
	localparam logic [2:0] REG_PERIOD   = 3'd4;
	localparam logic [2:0] REG_HALF     = 3'd5;

	// register reset values
	localparam logic [3:0] RST_DEBOUNCE = 4'd2;
	localparam logic [7:0] RST_WINDOW   = 8'd40;
	localparam logic [7:0] RST_HOLD     = 8'd20;
	localparam logic [7:0] RST_BLINK    = 8'd20;
	localparam logic [7:0] RST_PERIOD   = 8'd120;
	localparam logic [6:0] RST_HALF     = 7'd50;

	// reported action codes
	localparam logic [2:0] ACT_ON    = 3'd0;
	localparam logic [2:0] ACT_OFF   = 3'd1;
	localparam logic [2:0] ACT_IDLE  = 3'd2;
	localparam logic [2:0] ACT_HALF  = 3'd3;
	localparam logic [2:0] ACT_TRACK = 3'd4;

	// gesture thresholds and duty limit
	localparam logic [7:0] EDGE_HALF_MIN = 8'd2;
	localparam logic [7:0] EDGE_HALF_MAX = 8'd4;
	localparam logic [6:0] DUTY_MAX      = 7'd100;

	// x/100 as (x * RECIP) >> RECIP_SHIFT, exact for x below 43690
	localparam logic [15:0] RECIP       = 16'd41944;
	localparam int          RECIP_SHIFT = 22;

	// controller mode; the idle variants remember what continues
	typedef enum logic [6:0] {
		MODE_ON        = 7'b0000001,
		MODE_OFF       = 7'b0000010,
		MODE_IDLE      = 7'b0000100,
		MODE_HALF      = 7'b0001000,
		MODE_TRACK     = 7'b0010000,
		MODE_IDLE_TRK  = 7'b0100000,
		MODE_IDLE_HALF = 7'b1000000
	} mode_t;

	typedef struct packed {
		logic [3:0] debounce_ticks;
		logic [7:0] window_ticks;
		logic [7:0] hold_ticks_min;
		logic [7:0] blink_tick;
		logic [7:0] period_counts;
		logic [6:0] half_percent;
	} cfg_t;

	// pipeline advance / input beat taken
	typedef struct packed {
		logic adv;
		logic take;
	} ctl_t;

	// result fields other than the compare value
	typedef struct packed {
		logic [2:0] action_code;
		logic       power_on;
		logic       pwm_enable;
		logic       led_level;
		logic [6:0] duty_percent;
	} stage_t;

	function automatic logic [7:0] sat_inc8(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	function automatic logic [2:0] action_of(input mode_t m);
		logic [2:0] a;
		unique case (m)
			MODE_ON:    a = ACT_ON;
			MODE_OFF:   a = ACT_OFF;
			MODE_HALF:  a = ACT_HALF;
			MODE_TRACK: a = ACT_TRACK;
			default:    a = ACT_IDLE;
		endcase
		return a;
	endfunction

endpackage

// ----- hdl/bgpdt_if.sv -----
// ----------------------------------------------------------------------------
// bgpdt channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bgpdt_in_if;
	logic valid;
	logic ready;
	logic func;
	logic button_level;
	logic feedback_level;

	modport source (output valid, func, button_level, feedback_level, input ready);
	modport sink (input valid, func, button_level, feedback_level, output ready);
endinterface

interface bgpdt_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] action_code;
	logic       power_on;
	logic       pwm_enable;
	logic       led_level;
	logic [6:0] duty_percent;
	logic [7:0] compare_value;

	modport source (output valid, action_code, power_on, pwm_enable, led_level,
		duty_percent, compare_value, input ready);
	modport sink (input valid, action_code, power_on, pwm_enable, led_level,
		duty_percent, compare_value, output ready);
endinterface

// ----- hdl/bgpdt_gesture.sv -----
// ----------------------------------------------------------------------------
// bgpdt_gesture
// Debounce, gesture window classification and duty tracking; stage 1.
// ----------------------------------------------------------------------------
module bgpdt_gesture (
	input  logic                clk,
	input  logic                arst_n,
	input  bgpdt_pkg::cfg_t     cfg,
	input  bgpdt_pkg::ctl_t     ctl,
	input  logic                func,
	input  logic                button_level,
	input  logic                feedback_level,
	output logic                valid_s1,
	output bgpdt_pkg::stage_t   stage_s1
);
	import bgpdt_pkg::*;

	// controller state
	logic [7:0] tiw_q;
	logic [3:0] stable_q;
	logic       prev_raw_q;
	logic       clean_q;
	logic       prev_clean_q;
	logic [7:0] held_q;
	logic [7:0] edge_q;
	mode_t      mode_q;
	logic       running_q;
	logic       pwm_q;
	logic       led_q;
	logic [6:0] duty_q;

	// next state
	logic [7:0] tiw_d;
	logic [3:0] stable_d;
	logic       clean_d;
	logic [7:0] held_d;
	logic [7:0] edge_d;
	mode_t      mode_d;
	logic       running_d;
	logic       pwm_d;
	logic       led_d;
	logic [6:0] duty_d;
	logic       tracking;

	assign tracking = (mode_q == MODE_ON) || (mode_q == MODE_TRACK) ||
		(mode_q == MODE_IDLE_TRK);

	always_comb begin
		tiw_d     = tiw_q;
		stable_d  = stable_q;
		clean_d   = clean_q;
		held_d    = held_q;
		edge_d    = edge_q;
		mode_d    = mode_q;
		running_d = running_q;
		pwm_d     = pwm_q;
		led_d     = led_q;
		duty_d    = duty_q;
		if (!func) begin
			// window tick
			tiw_d = sat_inc8(tiw_q);
			if (mode_q == MODE_HALF && tiw_d == cfg.blink_tick)
				led_d = ~led_q;

			// debounce against previous raw sample; count caps at 15
			if (button_level == prev_raw_q)
				stable_d = (stable_q == 4'hF) ? stable_q : stable_q + 4'd1;
			else
				stable_d = '0;
			if (stable_d >= cfg.debounce_ticks)
				clean_d = button_level;

			// held ticks and clean edges
			if (!clean_d && !prev_clean_q)
				held_d = sat_inc8(held_q);
			else if (clean_d != prev_clean_q)
				edge_d = sat_inc8(edge_q);

			// window end: classify and clear counters
			if (tiw_d >= cfg.window_ticks) begin
				if (held_d >= cfg.hold_ticks_min) begin
					if (running_q) begin
						mode_d    = MODE_OFF;
						running_d = 1'b0;
						pwm_d     = 1'b0;
						led_d     = 1'b0;
					end else begin
						mode_d    = MODE_ON;
						running_d = 1'b1;
						pwm_d     = 1'b1;
						led_d     = 1'b1;
					end
				end else if (edge_d >= EDGE_HALF_MIN && edge_d <= EDGE_HALF_MAX) begin
					mode_d    = MODE_HALF;
					running_d = 1'b1;
					duty_d    = (cfg.half_percent > DUTY_MAX) ? DUTY_MAX : cfg.half_percent;
				end else if (edge_d > EDGE_HALF_MAX) begin
					mode_d    = MODE_TRACK;
					running_d = 1'b1;
					pwm_d     = 1'b1;
					led_d     = 1'b1;
				end else if (tracking) begin
					mode_d = MODE_IDLE_TRK;
				end else if (mode_q == MODE_HALF || mode_q == MODE_IDLE_HALF) begin
					mode_d = MODE_IDLE_HALF;
				end else begin
					mode_d = MODE_IDLE;
				end
				tiw_d  = '0;
				held_d = '0;
				edge_d = '0;
			end
		end else if (tracking) begin
			// control step: step duty against feedback
			if (feedback_level) begin
				if (duty_q != '0)
					duty_d = duty_q - 7'd1;
			end else if (duty_q < DUTY_MAX) begin
				duty_d = duty_q + 7'd1;
			end
		end
	end

	// state registers, updated on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiw_q        <= '0;
			stable_q     <= '0;
			prev_raw_q   <= 1'b1;
			clean_q      <= 1'b1;
			prev_clean_q <= 1'b1;
			held_q       <= '0;
			edge_q       <= '0;
			mode_q       <= MODE_OFF;
			running_q    <= 1'b0;
			pwm_q        <= 1'b0;
			led_q        <= 1'b0;
			duty_q       <= RST_HALF;
		end else if (ctl.take) begin
			tiw_q      <= tiw_d;
			stable_q   <= stable_d;
			clean_q    <= clean_d;
			held_q     <= held_d;
			edge_q     <= edge_d;
			mode_q     <= mode_d;
			running_q  <= running_d;
			pwm_q      <= pwm_d;
			led_q      <= led_d;
			duty_q     <= duty_d;
			if (!func) begin
				prev_raw_q   <= button_level;
				prev_clean_q <= clean_d;
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (ctl.adv)
			valid_s1 <= ctl.take;
	end

	// stage 1 payload: fields from the updated state
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			stage_s1.action_code  <= action_of(mode_d);
			stage_s1.power_on     <= running_d;
			stage_s1.pwm_enable   <= pwm_d;
			stage_s1.led_level    <= led_d;
			stage_s1.duty_percent <= duty_d;
		end
	end

endmodule

// ----- hdl/bgpdt_compare.sv -----
// ----------------------------------------------------------------------------
// bgpdt_compare
// PWM compare value: period*duty in stage 2, /100 and negate in stage 3.
// ----------------------------------------------------------------------------
module bgpdt_compare (
	input  logic              clk,
	input  logic              arst_n,
	input  bgpdt_pkg::ctl_t   ctl,
	input  logic [7:0]        period_counts,
	input  logic              valid_s1,
	input  bgpdt_pkg::stage_t stage_s1,
	output logic              valid_s3,
	output bgpdt_pkg::stage_t stage_s3,
	output logic [7:0]        compare_s3
);
	import bgpdt_pkg::*;

	logic        valid_s2;
	stage_t      stage_s2;
	logic [14:0] prod_s2;
	logic [14:0] prod;
	logic [30:0] scaled;
	logic [7:0]  counts;

	// period * duty, at most 25500
	assign prod = {7'd0, period_counts} * {8'd0, stage_s1.duty_percent};

	// counts = prod / 100 by reciprocal; reload + period wraps to zero
	assign scaled = {16'd0, prod_s2} * {15'd0, RECIP};
	assign counts = scaled[RECIP_SHIFT +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (ctl.adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			stage_s2   <= stage_s1;
			prod_s2    <= prod;
			stage_s3   <= stage_s2;
			compare_s3 <= 8'd0 - counts;
		end
	end

endmodule

// ----- hdl/button_gesture_pwm_duty_tracker_core.sv -----
// ----------------------------------------------------------------------------
// button_gesture_pwm_duty_tracker_core
// Debounced button gesture classifier driving a PWM duty tracker.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  item     | in  | valid/ready  | func, button_level, feedback_level
//  result   | out | valid/ready  | action_code, power_on, pwm_enable,
//           |     |              | led_level, duty_percent, compare_value
//  wr_*     | in  | wr_en only   | wr_index (3 b), wr_data (8 b)
//
// One beat per cycle while the result is not stalled; each item's result
// passes through three register stages (state update, period*duty multiply,
// reciprocal divide by 100) before it is valid.
// A stalled result freezes all three stages; item.ready is low only then.
// Reset loads the register defaults and the controller state at once.
// ----------------------------------------------------------------------------
`include "button_gesture_pwm_duty_tracker_core_defines.svh"

module button_gesture_pwm_duty_tracker_core (
	input  logic       clk,
	input  logic       arst_n,
	bgpdt_in_if.sink   item,
	bgpdt_out_if.source result,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [7:0] wr_data
);
	import bgpdt_pkg::*;

	cfg_t       cfg_q;
	ctl_t       ctl;
	logic       valid_s1;
	stage_t     stage_s1;
	logic       valid_s3;
	stage_t     stage_s3;
	logic [7:0] compare_s3;

	// pipeline moves unless a result is held
	assign ctl.adv    = !valid_s3 || result.ready;
	assign ctl.take   = item.valid && ctl.adv;
	assign item.ready = ctl.adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= RST_DEBOUNCE;
			cfg_q.window_ticks   <= RST_WINDOW;
			cfg_q.hold_ticks_min <= RST_HOLD;
			cfg_q.blink_tick     <= RST_BLINK;
			cfg_q.period_counts  <= RST_PERIOD;
			cfg_q.half_percent   <= RST_HALF;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DEBOUNCE: cfg_q.debounce_ticks <= wr_data[3:0];
				REG_WINDOW:   cfg_q.window_ticks   <= wr_data;
				REG_HOLD:     cfg_q.hold_ticks_min <= wr_data;
				REG_BLINK:    cfg_q.blink_tick     <= wr_data;
				REG_PERIOD:   cfg_q.period_counts  <= wr_data;
				REG_HALF:     cfg_q.half_percent   <= wr_data[6:0];
				default: ;
			endcase
		end
	end

	bgpdt_gesture u_gesture (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.ctl            (ctl),
		.func           (item.func),
		.button_level   (item.button_level),
		.feedback_level (item.feedback_level),
		.valid_s1       (valid_s1),
		.stage_s1       (stage_s1)
	);

	bgpdt_compare u_compare (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.period_counts (cfg_q.period_counts),
		.valid_s1      (valid_s1),
		.stage_s1      (stage_s1),
		.valid_s3      (valid_s3),
		.stage_s3      (stage_s3),
		.compare_s3    (compare_s3)
	);

	// result drive
	assign result.valid         = valid_s3;
	assign result.action_code   = stage_s3.action_code;
	assign result.power_on      = stage_s3.power_on;
	assign result.pwm_enable    = stage_s3.pwm_enable;
	assign result.led_level     = stage_s3.led_level;
	assign result.duty_percent  = stage_s3.duty_percent;
	assign result.compare_value = compare_s3;

	// checks
	`BGPDT_ASSERT_NEXT(a_take_fills_s1, ctl.take, valid_s1, "accepted beat did not reach stage 1")
	`BGPDT_ASSERT_NOW(a_duty_range, result.valid, result.duty_percent <= DUTY_MAX, "duty above limit")
	`BGPDT_ASSERT_NOW(a_off_quiet, result.valid && !result.power_on, !result.pwm_enable && !result.led_level, "pwm or led active while off")

endmodule

// ----- sim/bgpdt_tracker_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bgpdt_tracker_checker
// Watches the item, result and register-write ports of the gesture / duty
// tracker core. It keeps its own copy of the controller state, works out the
// result of every accepted item, and compares each result beat, field by
// field, with the oldest expected one.
// ----------------------------------------------------------------------------
module bgpdt_tracker_checker (
	input  logic       clk,
	input  logic       arst_n,
	bgpdt_in_if        item,
	bgpdt_out_if       result,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [7:0] wr_data,
	output int         mismatches,
	output int         pending
);
	import bgpdt_pkg::*;

	typedef struct packed {
		stage_t     fields;
		logic [7:0] compare_value;
	} tracker_result_t;

	// shadow registers and controller state
	cfg_t       cfg;
	logic [7:0] tick_cnt;
	logic [7:0] stable_cnt;
	logic [7:0] held_cnt;
	logic [7:0] edge_cnt;
	logic       raw_last;
	logic       clean;
	logic       clean_last;
	mode_t      mode;
	logic       running;
	logic       pwm_run;
	logic       led;
	logic [6:0] duty;
	int         err_cnt;

	tracker_result_t expected_q[$];

	// count up, stick at all ones
	function automatic logic [7:0] bump(input logic [7:0] v);
		return v + {7'd0, ~&v};
	endfunction

	// duty follows feedback only in on, track, or idle after one of them
	function automatic logic duty_follows();
		return (mode == MODE_ON) || (mode == MODE_TRACK) || (mode == MODE_IDLE_TRK);
	endfunction

	function automatic logic [2:0] reported_action(input mode_t m);
		case (m)
			MODE_ON:    return ACT_ON;
			MODE_OFF:   return ACT_OFF;
			MODE_HALF:  return ACT_HALF;
			MODE_TRACK: return ACT_TRACK;
			default:    return ACT_IDLE;
		endcase
	endfunction

	// reload + T - T*duty/100, kept to 8 bits
	function automatic logic [7:0] compare_for(input logic [7:0] period, input logic [6:0] pct);
		int span;
		int reload;
		int counts;
		span   = int'(period);
		reload = (256 - span) & 255;
		counts = (span * int'(pct)) / 100;
		return 8'(reload + span - counts);
	endfunction

	// gesture decision at the end of a window
	task automatic close_window();
		if (held_cnt >= cfg.hold_ticks_min) begin
			if (running) begin
				mode = MODE_OFF;
				running = 1'b0;
				pwm_run = 1'b0;
				led = 1'b0;
			end else begin
				mode = MODE_ON;
				running = 1'b1;
				pwm_run = 1'b1;
				led = 1'b1;
			end
		end else if (edge_cnt >= EDGE_HALF_MIN && edge_cnt <= EDGE_HALF_MAX) begin
			mode = MODE_HALF;
			running = 1'b1;
			duty = (cfg.half_percent > DUTY_MAX) ? DUTY_MAX : cfg.half_percent;
		end else if (edge_cnt > EDGE_HALF_MAX) begin
			mode = MODE_TRACK;
			running = 1'b1;
			pwm_run = 1'b1;
			led = 1'b1;
		end else if (duty_follows()) begin
			mode = MODE_IDLE_TRK;
		end else if (mode == MODE_HALF || mode == MODE_IDLE_HALF) begin
			mode = MODE_IDLE_HALF;
		end else begin
			mode = MODE_IDLE;
		end
		tick_cnt = 8'd0;
		held_cnt = 8'd0;
		edge_cnt = 8'd0;
	endtask

	task automatic step_tracker(input logic is_ctl, input logic btn, input logic fb);
		if (!is_ctl) begin
			tick_cnt = bump(tick_cnt);
			if (mode == MODE_HALF && tick_cnt == cfg.blink_tick)
				led = ~led;
			// debounce against the previous raw sample
			stable_cnt = (btn == raw_last) ? bump(stable_cnt) : 8'd0;
			raw_last = btn;
			if (stable_cnt >= {4'd0, cfg.debounce_ticks})
				clean = btn;
			if (!clean && !clean_last)
				held_cnt = bump(held_cnt);
			else if (clean != clean_last)
				edge_cnt = bump(edge_cnt);
			if (tick_cnt >= cfg.window_ticks)
				close_window();
			clean_last = clean;
		end else if (duty_follows()) begin
			if (fb) begin
				if (duty != 7'd0)
					duty = duty - 7'd1;
			end else if (duty < DUTY_MAX) begin
				duty = duty + 7'd1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tracker_result_t want;
		tracker_result_t got;
		if (!arst_n) begin
			cfg = '{debounce_ticks: RST_DEBOUNCE, window_ticks: RST_WINDOW,
				hold_ticks_min: RST_HOLD, blink_tick: RST_BLINK,
				period_counts: RST_PERIOD, half_percent: RST_HALF};
			tick_cnt = 8'd0;
			stable_cnt = 8'd0;
			held_cnt = 8'd0;
			edge_cnt = 8'd0;
			raw_last = 1'b1;
			clean = 1'b1;
			clean_last = 1'b1;
			mode = MODE_OFF;
			running = 1'b0;
			pwm_run = 1'b0;
			led = 1'b0;
			duty = RST_HALF;
			err_cnt = 0;
			expected_q.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			// register writes
			if (wr_en) begin
				case (wr_index)
					REG_DEBOUNCE: cfg.debounce_ticks = wr_data[3:0];
					REG_WINDOW:   cfg.window_ticks = wr_data;
					REG_HOLD:     cfg.hold_ticks_min = wr_data;
					REG_BLINK:    cfg.blink_tick = wr_data;
					REG_PERIOD:   cfg.period_counts = wr_data;
					REG_HALF:     cfg.half_percent = wr_data[6:0];
					default:      ;
				endcase
			end

			// item beat: advance the model and queue its result
			if (item.valid && item.ready) begin
				step_tracker(item.func, item.button_level, item.feedback_level);
				want.fields.action_code = reported_action(mode);
				want.fields.power_on = running;
				want.fields.pwm_enable = pwm_run;
				want.fields.led_level = led;
				want.fields.duty_percent = duty;
				want.compare_value = compare_for(cfg.period_counts, duty);
				expected_q.push_back(want);
			end

			// result beat: check against the oldest expectation
			if (result.valid && result.ready) begin
				got.fields.action_code = result.action_code;
				got.fields.power_on = result.power_on;
				got.fields.pwm_enable = result.pwm_enable;
				got.fields.led_level = result.led_level;
				got.fields.duty_percent = result.duty_percent;
				got.compare_value = result.compare_value;
				if (expected_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: result beat with nothing expected: act=%0d cmp=%0d",
							$realtime, got.fields.action_code, got.compare_value);
				end else begin
					want = expected_q.pop_front();
					if (got.fields.action_code !== want.fields.action_code ||
						got.fields.power_on !== want.fields.power_on ||
						got.fields.pwm_enable !== want.fields.pwm_enable ||
						got.fields.led_level !== want.fields.led_level ||
						got.fields.duty_percent !== want.fields.duty_percent ||
						got.compare_value !== want.compare_value) begin
						err_cnt++;
						if (err_cnt <= 10) begin
							$display("%0t: expected act=%0d pwr=%0b pwm=%0b led=%0b duty=%0d cmp=%0d",
								$realtime, want.fields.action_code, want.fields.power_on,
								want.fields.pwm_enable, want.fields.led_level,
								want.fields.duty_percent, want.compare_value);
							$display("%0t:   actual act=%0d pwr=%0b pwm=%0b led=%0b duty=%0d cmp=%0d",
								$realtime, got.fields.action_code, got.fields.power_on,
								got.fields.pwm_enable, got.fields.led_level,
								got.fields.duty_percent, got.compare_value);
						end
					end
				end
			end
			mismatches <= err_cnt;
			pending <= expected_q.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the gesture / duty tracker core: a short directed run through
// the window decisions and duty stepping, then phases of random gestures
// (long presses, click trains, idle stretches, feedback runs, noise) under
// several register settings. The sender bursts, the receiver stalls; the
// checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	import bgpdt_pkg::*;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	logic       clk;
	logic       arst_n;
	logic       wr_en;
	logic [2:0] wr_index;
	logic [7:0] wr_data;
	int         mismatches;
	int         pending;
	int         holdoff_asked;
	int         holdoff_done;
	int         burst_left;
	int         phase_items;
	cfg_t       cur_cfg;

	bgpdt_in_if  item_ch ();
	bgpdt_out_if result_ch ();

	button_gesture_pwm_duty_tracker_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	bgpdt_tracker_checker tracker_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// offer one item beat; bursts of random length with random gaps between
	task automatic offer(input logic f, input logic btn, input logic fb);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
			burst_left = $urandom_range(40, 1);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= f;
		item_ch.button_level <= btn;
		item_ch.feedback_level <= fb;
		do @(posedge clk); while (!item_ch.ready);
		burst_left--;
		phase_items++;
	endtask

	// n window ticks at one button level
	task automatic hold_button(input logic lvl, input int n);
		repeat (n) offer(FUNC_TICK, lvl, 1'($urandom_range(1)));
	endtask

	task automatic wait_for_results();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [7:0] d);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(posedge clk);
	endtask

	// core idle: write all six registers, unused upper bits random
	task automatic load_settings(input cfg_t c);
		wait_for_results();
		put_reg(REG_DEBOUNCE, {4'($urandom_range(15)), c.debounce_ticks});
		put_reg(REG_WINDOW, c.window_ticks);
		put_reg(REG_HOLD, c.hold_ticks_min);
		put_reg(REG_BLINK, c.blink_tick);
		put_reg(REG_PERIOD, c.period_counts);
		put_reg(REG_HALF, {1'($urandom_range(1)), c.half_percent});
		wr_en <= 1'b0;
		cur_cfg = c;
	endtask

	// receiver: stall pattern in stretches, plus long hold-offs on request
	initial begin
		int stretch;
		int pct;
		result_ch.ready = 1'b0;
		holdoff_done = 0;
		forever begin
			stretch = $urandom_range(120, 10);
			case ($urandom_range(3))
				0: pct = 0;
				1: pct = 30;
				2: pct = 60;
				default: pct = 90;
			endcase
			repeat (stretch) begin
				if (holdoff_done != holdoff_asked) begin
					holdoff_done++;
					result_ch.ready <= 1'b0;
					repeat (64) @(posedge clk);
				end
				result_ch.ready <= ($urandom_range(99) >= pct);
				@(posedge clk);
			end
		end
	end

	// stimulus
	initial begin
		cfg_t plan;
		int   n;
		int   k;
		int   kind;
		int   win;
		logic fb;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_DEBOUNCE;
		wr_data = 8'd0;
		item_ch.valid = 1'b0;
		item_ch.func = FUNC_TICK;
		item_ch.button_level = 1'b1;
		item_ch.feedback_level = 1'b0;
		holdoff_asked = 0;
		burst_left = 0;
		cur_cfg = '{debounce_ticks: RST_DEBOUNCE, window_ticks: RST_WINDOW,
			hold_ticks_min: RST_HOLD, blink_tick: RST_BLINK,
			period_counts: RST_PERIOD, half_percent: RST_HALF};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// powered off: control steps only report
		offer(FUNC_STEP, 1'b0, 1'b0);
		offer(FUNC_STEP, 1'b1, 1'b1);

		// zero window: every tick ends a window; period 0, half above 100
		plan = '{debounce_ticks: 4'd0, window_ticks: 8'd0, hold_ticks_min: 8'd1,
			blink_tick: 8'd0, period_counts: 8'd0, half_percent: 7'd127};
		load_settings(plan);
		offer(FUNC_TICK, 1'b0, 1'b1);   // press edge, idle
		offer(FUNC_TICK, 1'b0, 1'b0);   // held, power on
		offer(FUNC_STEP, 1'b1, 1'b0);   // duty up
		offer(FUNC_STEP, 1'b0, 1'b1);   // duty down
		offer(FUNC_TICK, 1'b0, 1'b1);   // held again, power off
		offer(FUNC_TICK, 1'b1, 1'b0);   // release edge, plain idle
		offer(FUNC_TICK, 1'b0, 1'b0);
		offer(FUNC_TICK, 1'b0, 1'b1);   // power on
		offer(FUNC_TICK, 1'b1, 1'b0);   // idle, tracking continues
		offer(FUNC_STEP, 1'b0, 1'b0);

		// four button toggles in a short window give half duty, then the LED blinks
		plan = '{debounce_ticks: 4'd0, window_ticks: 8'd6, hold_ticks_min: 8'd255,
			blink_tick: 8'd2, period_counts: 8'd255, half_percent: 7'd100};
		load_settings(plan);
		offer(FUNC_TICK, 1'b0, 1'b0);
		offer(FUNC_TICK, 1'b1, 1'b1);
		offer(FUNC_TICK, 1'b0, 1'b0);
		offer(FUNC_TICK, 1'b1, 1'b1);
		hold_button(1'b1, 8);
		offer(FUNC_STEP, 1'b0, 1'b0);   // half duty holds the duty

		// random gesture phases
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: plan = '{debounce_ticks: RST_DEBOUNCE, window_ticks: RST_WINDOW,
					hold_ticks_min: RST_HOLD, blink_tick: RST_BLINK,
					period_counts: RST_PERIOD, half_percent: RST_HALF};
				1: plan = '{debounce_ticks: 4'd0, window_ticks: 8'd1, hold_ticks_min: 8'd0,
					blink_tick: 8'd0, period_counts: 8'd1, half_percent: 7'd0};
				2: plan = '{debounce_ticks: 4'd15, window_ticks: 8'd255,
					hold_ticks_min: 8'd255, blink_tick: 8'd255, period_counts: 8'd255,
					half_percent: 7'd100};
				3: plan = '{debounce_ticks: 4'd1, window_ticks: 8'd16, hold_ticks_min: 8'd8,
					blink_tick: 8'd5, period_counts: 8'd200, half_percent: 7'd127};
				default: begin
					win = $urandom_range(40, 4);
					plan.debounce_ticks = 4'($urandom_range(3));
					plan.window_ticks = 8'(win);
					plan.hold_ticks_min = 8'($urandom_range(win, 1));
					plan.blink_tick = 8'($urandom_range(win));
					plan.period_counts = 8'($urandom_range(255));
					plan.half_percent = 7'($urandom_range(127));
				end
			endcase
			load_settings(plan);
			// long receiver hold-off while items keep coming
			if (phase == 3)
				holdoff_asked++;
			phase_items = 0;
			while (phase_items < 170) begin
				kind = $urandom_range(99);
				if (kind < 20) begin
					// long press
					n = cur_cfg.hold_ticks_min + cur_cfg.debounce_ticks + $urandom_range(12, 1);
					hold_button(1'b0, (n > 300) ? 300 : n);
					hold_button(1'b1, cur_cfg.debounce_ticks + $urandom_range(4, 1));
				end else if (kind < 45) begin
					// click train
					k = $urandom_range(7, 1);
					repeat (k) begin
						hold_button(1'b0, cur_cfg.debounce_ticks + $urandom_range(3, 1));
						hold_button(1'b1, cur_cfg.debounce_ticks + $urandom_range(3, 1));
					end
				end else if (kind < 60) begin
					n = $urandom_range(cur_cfg.window_ticks + 2, 1);
					hold_button(1'b1, (n > 300) ? 300 : n);
				end else if (kind < 85) begin
					// feedback run, sometimes long enough to pin the duty
					n = ($urandom_range(9) == 0) ? $urandom_range(120, 100) : $urandom_range(20, 1);
					fb = 1'($urandom_range(1));
					k = $urandom_range(1);
					repeat (n)
						offer(FUNC_STEP, 1'($urandom_range(1)),
							(k != 0) ? fb : 1'($urandom_range(1)));
				end else begin
					// bouncing button and mixed items
					repeat ($urandom_range(12, 1))
						offer(1'($urandom_range(1)), 1'($urandom_range(1)),
							1'($urandom_range(1)));
				end
			end
		end

		wait_for_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("[button_gesture_pwm_duty_tracker_core] OK");
		end else begin
			$display("[button_gesture_pwm_duty_tracker_core] ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("[button_gesture_pwm_duty_tracker_core] ERROR");
		$finish;
	end

endmodule
